// ----- rtl/ech_pkg.sv -----
// ---------------------------------------------------------------------------
// ech_pkg
// Types and constants shared by the event counter / histogram store.
// ---------------------------------------------------------------------------
package ech_pkg;

    localparam int DATA_W     = 64;
    localparam int NUM_BOUNDS = 6;
    localparam int MASK_W     = 32;

    // configuration register indexes
    localparam logic [2:0] CFG_BUCKET_COUNT = 3'd0;
    localparam logic [2:0] CFG_HIST_MASK    = 3'd1;
    localparam logic [2:0] CFG_BOUND_0      = 3'd2;

    // lanes of one slot row in the back-end memory
    localparam int LANE_COUNTER = 0;
    localparam int LANE_GAUGE   = 1;
    localparam int LANE_SUM     = 2;
    localparam int LANE_BKT0    = 3;

    typedef enum logic [1:0] {
        REQ_ADD  = 2'd0,
        REQ_SET  = 2'd1,
        REQ_OBS  = 2'd2,
        REQ_READ = 2'd3
    } req_op_t;

    typedef struct packed {
        req_op_t             req_type;
        logic [7:0]          slot;
        logic [DATA_W-1:0]   amount;
        logic [2:0]          bucket_sel;
    } in_word_t;

    typedef struct packed {
        logic [DATA_W-1:0]   counter_value;
        logic [DATA_W-1:0]   gauge_value;
        logic [DATA_W-1:0]   hist_sum;
        logic [DATA_W-1:0]   bucket_hits;
    } out_word_t;

    // classified command: lane is the bucket to bump (observe) or to return (read)
    typedef struct packed {
        req_op_t             op;
        logic [7:0]          slot;
        logic [DATA_W-1:0]   amount;
        logic [2:0]          lane;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } back_state_t;

endpackage

// ----- rtl/ech_fifo.sv -----
// ---------------------------------------------------------------------------
// ech_fifo
// Two-entry queue used between front and back end and on the result side.
// ---------------------------------------------------------------------------
module ech_fifo #(
    parameter type word_t = logic [7:0]
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  word_t wr_data,
    output logic  full,
    input  logic  pop,
    output word_t rd_data,
    output logic  empty
);

    word_t       mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/ech_front.sv -----
// ---------------------------------------------------------------------------
// ech_front
// Holds the configuration registers, drops items that have no effect and
// picks the histogram bucket of each observation.
// ---------------------------------------------------------------------------
module ech_front
    import ech_pkg::*;
#(
    parameter int SLOT_COUNT  = 32,
    parameter int MAX_BUCKETS = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [DATA_W-1:0] cfg_data,
    input  logic              accept,
    input  in_word_t          req,
    output logic              cmd_push,
    output cmd_t              cmd
);

    logic [2:0]        bucket_count_reg;
    logic [MASK_W-1:0] hist_mask_reg;
    logic [DATA_W-1:0] bound_reg [NUM_BOUNDS];

    logic [2:0]        used_bounds;
    logic [2:0]        bkt;
    logic              in_range;
    logic              observes;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= 3'd0;
            hist_mask_reg    <= '0;
            for (int i = 0; i < NUM_BOUNDS; i++)
            begin
                bound_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BUCKET_COUNT: bucket_count_reg <= cfg_data[2:0];
                CFG_HIST_MASK:    hist_mask_reg    <= cfg_data[MASK_W-1:0];
                default:          bound_reg[3'(cfg_index - CFG_BOUND_0)] <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        used_bounds = (bucket_count_reg > 3'(MAX_BUCKETS)) ? 3'(MAX_BUCKETS)
                                                           : bucket_count_reg;
        // walk down so the lowest-indexed matching bound wins
        bkt = used_bounds;
        for (int i = MAX_BUCKETS - 1; i >= 0; i--)
        begin
            if ((3'(i) < used_bounds) && (bound_reg[i] >= req.amount))
            begin
                bkt = 3'(i);
            end
        end
    end

    assign in_range = ({1'b0, req.slot} < 9'(SLOT_COUNT));
    assign observes = (req.slot < 8'(MASK_W)) && hist_mask_reg[req.slot[4:0]];

    always_comb
    begin
        cmd.op     = req.req_type;
        cmd.slot   = req.slot;
        cmd.amount = req.amount;
        cmd.lane   = (req.req_type == REQ_OBS) ? bkt : req.bucket_sel;
        cmd_push   = accept && in_range && !((req.req_type == REQ_OBS) && !observes);
    end

endmodule

// ----- rtl/ech_back.sv -----
// ---------------------------------------------------------------------------
// ech_back
// Slot row memory with read-modify-write sequencer; clears the memory after
// reset and produces read results.
// ---------------------------------------------------------------------------
module ech_back
    import ech_pkg::*;
#(
    parameter int SLOT_COUNT  = 32,
    parameter int MAX_BUCKETS = 6
) (
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd,
    input  logic      cmd_empty,
    output logic      cmd_pop,
    input  logic      res_full,
    output logic      res_push,
    output out_word_t res,
    output logic      clearing
);

    localparam int LANES  = MAX_BUCKETS + 4;
    localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef logic [LANES-1:0][DATA_W-1:0] row_t;

    row_t              mem [SLOT_COUNT];
    row_t              row_reg;
    row_t              wr_row;
    cmd_t              cmd_reg;
    back_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic              take;

    logic [DATA_W-1:0] acc_old, acc_new;
    logic [DATA_W-1:0] bkt_old, bkt_new;
    logic [DATA_W-1:0] hits;
    row_t              upd_row;

    // reads wait for room on the result side
    assign take = !cmd_empty && !((cmd.op == REQ_READ) && res_full);

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            BK_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(SLOT_COUNT - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (take)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:  state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    // row update for the command in execution
    always_comb
    begin
        acc_old = (cmd_reg.op == REQ_ADD) ? row_reg[LANE_COUNTER] : row_reg[LANE_SUM];
        acc_new = acc_old + cmd_reg.amount;
        bkt_old = '0;
        hits    = '0;
        for (int i = 0; i <= MAX_BUCKETS; i++)
        begin
            if (cmd_reg.lane == 3'(i))
            begin
                bkt_old = row_reg[LANE_BKT0 + i];
                hits    = row_reg[LANE_BKT0 + i];
            end
        end
        bkt_new = bkt_old + 64'd1;

        upd_row = row_reg;
        unique case (cmd_reg.op)
            REQ_ADD:  upd_row[LANE_COUNTER] = acc_new;
            REQ_SET:  upd_row[LANE_GAUGE]   = cmd_reg.amount;
            REQ_OBS:
            begin
                upd_row[LANE_SUM] = acc_new;
                for (int i = 0; i <= MAX_BUCKETS; i++)
                begin
                    if (cmd_reg.lane == 3'(i))
                    begin
                        upd_row[LANE_BKT0 + i] = bkt_new;
                    end
                end
            end
            REQ_READ: upd_row = row_reg;
        endcase

        res.counter_value = row_reg[LANE_COUNTER];
        res.gauge_value   = row_reg[LANE_GAUGE];
        res.hist_sum      = row_reg[LANE_SUM];
        res.bucket_hits   = hits;
    end

    always_comb
    begin
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        wr_addr  = cmd_reg.slot[ADDR_W-1:0];
        rd_addr  = cmd.slot[ADDR_W-1:0];
        wr_row   = upd_row;
        cmd_pop  = 1'b0;
        res_push = 1'b0;
        clearing = 1'b0;
        unique case (state_reg)
            BK_CLEAR:
            begin
                clearing = 1'b1;
                mem_we   = 1'b1;
                wr_addr  = clr_cnt_reg;
                wr_row   = '0;
            end
            BK_IDLE:
            begin
                cmd_pop = take;
                mem_re  = take;
            end
            BK_EXEC:
            begin
                mem_we   = (cmd_reg.op != REQ_READ);
                res_push = (cmd_reg.op == REQ_READ);
            end
            default:
            begin
                clearing = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_row;
        end
        if (mem_re)
        begin
            row_reg <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/event_counter_histogram_store.sv -----
// ---------------------------------------------------------------------------
// event_counter_histogram_store
// Per-slot counters, gauges and histograms with a queue interface.
// ---------------------------------------------------------------------------
// Each slot keeps one memory row (counter, gauge, histogram sum and
// MAX_BUCKETS+1 bucket counts). The back end finishes one word before it
// takes the next: it reads the slot row from the single-port row memory,
// then writes it back or queues the read result. A two-word queue sits
// between the classifying front end and the back end, so input is taken
// while the back end or the result side stalls. After reset the row memory
// is cleared row by row; full stays high during that pass, while
// configuration writes are taken. Words for slots at or above SLOT_COUNT, and
// observations for slots without a mask bit, are dropped at the input.
module event_counter_histogram_store
    import ech_pkg::*;
#(
    parameter int SLOT_COUNT  = 32,
    parameter int MAX_BUCKETS = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  in_word_t          req,
    input  logic              pop,
    output logic              empty,
    output out_word_t         rsp,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [DATA_W-1:0] cfg_data
);

    logic      accept;
    logic      cmd_push, cmd_full, cmd_empty, cmd_pop;
    cmd_t      cmd_in, cmd_out;
    logic      res_push, res_full;
    out_word_t res;
    logic      clearing;

    assign full   = cmd_full || clearing;
    assign accept = push && !full;

    ech_front #(
        .SLOT_COUNT  (SLOT_COUNT),
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .req       (req),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    ech_fifo #(
        .word_t (cmd_t)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    ech_back #(
        .SLOT_COUNT  (SLOT_COUNT),
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res),
        .clearing  (clearing)
    );

    ech_fifo #(
        .word_t (out_word_t)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res),
        .full    (res_full),
        .pop     (pop),
        .rd_data (rsp),
        .empty   (empty)
    );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives event words into the telemetry store and checks every read word
// against a cycle-free model of the slot counters, gauges and histograms.
// Both handshake sides stall at random; configuration is changed only
// while the store is drained.
// ---------------------------------------------------------------------------
module testbench;
    import ech_pkg::*;

    localparam int          SLOTS      = 32;
    localparam int          MAX_BKT    = 6;
    localparam int          SETTLE     = 16;
    localparam int          STUCK_MAX  = 2000;
    localparam int          PHASE_LEN  = 130;
    localparam logic [63:0] ALL_ONES   = {64{1'b1}};

    typedef logic [63:0] bound_set_t [NUM_BOUNDS];

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    in_word_t          req;
    logic              pop;
    logic              empty;
    out_word_t         rsp;
    logic              cfg_we;
    logic [2:0]        cfg_index;
    logic [DATA_W-1:0] cfg_data;

    // model of the store
    logic [63:0] counter_m [SLOTS];
    logic [63:0] gauge_m   [SLOTS];
    logic [63:0] sum_m     [SLOTS];
    logic [63:0] hits_m    [SLOTS][MAX_BKT+1];
    logic [2:0]  cur_bucket_count;
    logic [31:0] cur_mask;
    logic [63:0] cur_bounds [NUM_BOUNDS];

    out_word_t   pending_reads[$];
    int          fail_count;
    int          stuck_cycles;
    int          rx_hold;
    bit          tx_quiet;
    bit          rx_quiet;

    event_counter_histogram_store #(
        .SLOT_COUNT  (SLOTS),
        .MAX_BUCKETS (MAX_BKT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .pop       (pop),
        .empty     (empty),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------
    function automatic int pick_bucket(input logic [63:0] v);
        int n;
        n = (cur_bucket_count > MAX_BKT) ? MAX_BKT : int'(cur_bucket_count);
        for (int i = 0; i < n; i++)
        begin
            if (cur_bounds[i] >= v)
                return i;
        end
        return n;
    endfunction

    task automatic apply_event(input in_word_t w);
        out_word_t r;
        int        s;
        int        b;
        s = int'(w.slot);
        if (s >= SLOTS)
            return;
        case (w.req_type)
            REQ_ADD: counter_m[s] += w.amount;
            REQ_SET: gauge_m[s] = w.amount;
            REQ_OBS:
            begin
                if (cur_mask[s])
                begin
                    b = pick_bucket(w.amount);
                    hits_m[s][b] += 64'd1;
                    sum_m[s] += w.amount;
                end
            end
            default:
            begin
                r.counter_value = counter_m[s];
                r.gauge_value   = gauge_m[s];
                r.hist_sum      = sum_m[s];
                r.bucket_hits   = (w.bucket_sel <= MAX_BKT) ? hits_m[s][w.bucket_sel] : '0;
                pending_reads.push_back(r);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic in_word_t make_word(input req_op_t op, input logic [7:0] s,
                                           input logic [63:0] a, input logic [2:0] sel);
        in_word_t w;
        w.req_type   = op;
        w.slot       = s;
        w.amount     = a;
        w.bucket_sel = sel;
        return w;
    endfunction

    function automatic in_word_t rand_word();
        req_op_t     op;
        logic [7:0]  s;
        logic [63:0] a;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 25)
            op = REQ_ADD;
        else if (r < 40)
            op = REQ_SET;
        else if (r < 75)
            op = REQ_OBS;
        else
            op = REQ_READ;
        s = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, SLOTS - 1));
        case ($urandom_range(0, 3))
            0: a = {$urandom, $urandom};
            1: a = cur_bounds[$urandom_range(0, NUM_BOUNDS - 1)]
                   + 64'($urandom_range(0, 2)) - 64'd1;
            2: a = 64'($urandom_range(0, 100));
            default: a = $urandom_range(0, 1) ? ALL_ONES : 64'd0;
        endcase
        return make_word(op, s, a, 3'($urandom_range(0, 7)));
    endfunction

    task automatic pause_tx(input int n);
        if (n > 0)
        begin
            push <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_word(input in_word_t w);
        push <= 1'b1;
        req  <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        apply_event(w);
        pause_tx(tx_quiet ? 0 : rand_gap());
    endtask

    // drain all reads, then give trailing writes time to land
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        if (idx == CFG_BUCKET_COUNT)
            cur_bucket_count = d[2:0];
        else if (idx == CFG_HIST_MASK)
            cur_mask = d[31:0];
        else
            cur_bounds[idx - CFG_BOUND_0] = d;
    endtask

    task automatic set_config(input logic [2:0] bc, input logic [31:0] mask,
                              input bound_set_t b);
        write_reg(CFG_BUCKET_COUNT, {61'd0, bc});
        write_reg(CFG_HIST_MASK, {32'd0, mask});
        for (int i = 0; i < NUM_BOUNDS; i++)
            write_reg(CFG_BOUND_0 + 3'(i), b[i]);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_basic_ops();
        bound_set_t b;
        b = '{64'd10, 64'd100, ALL_ONES, 64'd0, 64'd0, 64'd0};
        set_config(3'd3, 32'h8000_0001, b);
        send_word(make_word(REQ_READ, 8'd0,   64'd0,    3'd0));
        send_word(make_word(REQ_ADD,  8'd0,   ALL_ONES, 3'd0));
        send_word(make_word(REQ_ADD,  8'd0,   64'd2,    3'd0));   // counter wraps
        send_word(make_word(REQ_SET,  8'd31,  ALL_ONES, 3'd0));
        send_word(make_word(REQ_SET,  8'd31,  64'd5,    3'd0));
        send_word(make_word(REQ_OBS,  8'd0,   64'd0,    3'd0));
        send_word(make_word(REQ_OBS,  8'd0,   64'd10,   3'd0));   // equal to bound
        send_word(make_word(REQ_OBS,  8'd0,   64'd11,   3'd0));
        send_word(make_word(REQ_OBS,  8'd0,   ALL_ONES, 3'd0));
        send_word(make_word(REQ_OBS,  8'd1,   64'd7,    3'd0));   // slot not in mask
        send_word(make_word(REQ_OBS,  8'd31,  64'd100,  3'd0));
        send_word(make_word(REQ_ADD,  8'd32,  64'd5,    3'd0));   // slot out of range
        send_word(make_word(REQ_READ, 8'd255, 64'd0,    3'd0));
        send_word(make_word(REQ_READ, 8'd0,   64'd0,    3'd0));
        send_word(make_word(REQ_READ, 8'd0,   64'd0,    3'd2));
        send_word(make_word(REQ_READ, 8'd0,   64'd0,    3'd7));   // select past last bucket
        send_word(make_word(REQ_READ, 8'd31,  64'd0,    3'd1));
        send_word(make_word(REQ_READ, 8'd1,   64'd0,    3'd0));
    endtask

    task automatic test_bucket_edges();
        bound_set_t b;
        b = '{64'd50, 64'd40, 64'd30, 64'd20, 64'd10, 64'd0};
        wait_idle();
        // count above the maximum, bounds descending
        set_config(3'd7, 32'hFFFF_FFFF, b);
        send_word(make_word(REQ_OBS,  8'd2, 64'd45, 3'd0));
        send_word(make_word(REQ_OBS,  8'd2, 64'd60, 3'd0));
        send_word(make_word(REQ_READ, 8'd2, 64'd0,  3'd6));
        send_word(make_word(REQ_READ, 8'd2, 64'd0,  3'd0));
        wait_idle();
        // no bounds: everything lands in bucket zero
        set_config(3'd0, 32'hFFFF_FFFF, b);
        send_word(make_word(REQ_OBS,  8'd3, 64'd5,  3'd0));
        send_word(make_word(REQ_READ, 8'd3, 64'd0,  3'd0));
        send_word(make_word(REQ_READ, 8'd3, 64'd0,  3'd3));
    endtask

    // result side held off while words keep coming: input must stall
    task automatic test_backpressure();
        tx_quiet = 1'b1;
        rx_hold  = 300;
        for (int i = 0; i < 40; i++)
            send_word(make_word(REQ_READ, 8'($urandom_range(0, SLOTS - 1)), 64'd0,
                                3'($urandom_range(0, 7))));
        tx_quiet = 1'b0;
    endtask

    task automatic test_random();
        bound_set_t b;
        logic [2:0]  bc;
        logic [31:0] mask;
        in_word_t    w;
        int          n;
        for (int p = 0; p < 6; p++)
        begin
            if ($urandom_range(0, 1) == 0 || p == 1)
            begin
                b[0] = (p == 1) ? 64'd0 : 64'($urandom_range(0, 50));
                for (int i = 1; i < NUM_BOUNDS; i++)
                    b[i] = b[i-1] + 64'($urandom_range(0, 1000));
                if (p == 1)
                    b[NUM_BOUNDS-1] = ALL_ONES;
            end
            else
            begin
                for (int i = 0; i < NUM_BOUNDS; i++)
                    b[i] = {$urandom, $urandom};
            end
            case (p)
                0: begin bc = 3'd0; mask = 32'hFFFF_FFFF; end
                1: begin bc = 3'd7; mask = $urandom; end
                2: begin bc = 3'd6; mask = 32'd0; end
                default: begin bc = 3'($urandom_range(0, 7)); mask = $urandom; end
            endcase
            wait_idle();
            set_config(bc, mask, b);
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            n = 0;
            while (n < PHASE_LEN)
            begin
                w = rand_word();
                send_word(w);
                if (w.slot < SLOTS)
                    n++;
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            counter_m[s] = '0;
            gauge_m[s]   = '0;
            sum_m[s]     = '0;
            for (int k = 0; k <= MAX_BKT; k++)
                hits_m[s][k] = '0;
        end
        cur_bucket_count = '0;
        cur_mask         = '0;
        for (int i = 0; i < NUM_BOUNDS; i++)
            cur_bounds[i] = '0;
        fail_count = 0;
        rx_hold    = 0;
        tx_quiet   = 1'b0;
        rx_quiet   = 1'b0;
        rst_n     <= 1'b0;
        push      <= 1'b0;
        req       <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_bucket_edges();
        test_backpressure();
        test_random();

        wait_idle();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending_reads.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // result side: random stalls, quiet stretches, and a long hold on request
    initial
    begin : result_drain
        int n;
        pop <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            n = rx_quiet ? 0 : rand_gap();
            if (rx_hold > 0)
            begin
                n       = rx_hold;
                rx_hold = 0;
            end
            if (n > 0)
            begin
                pop <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // compare each read word with the oldest expectation
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_reads.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %h", $time, rsp);
                fail_count++;
            end
            else
            begin
                want = pending_reads.pop_front();
                check_field("counter_value", want.counter_value, rsp.counter_value);
                check_field("gauge_value",   want.gauge_value,   rsp.gauge_value);
                check_field("hist_sum",      want.hist_sum,      rsp.hist_sum);
                check_field("bucket_hits",   want.bucket_hits,   rsp.bucket_hits);
            end
        end
    end

    // watchdog: cycles without any handshake
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || cfg_we)
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_MAX)
        begin
            $display("%0t: no progress for %0d cycles", $time, STUCK_MAX);
            $display("Verification failed");
            $finish;
        end
    end

    initial stuck_cycles = 0;

endmodule

// ----- files.f -----
rtl/ech_pkg.sv
rtl/ech_fifo.sv
rtl/ech_front.sv
rtl/ech_back.sv
rtl/event_counter_histogram_store.sv
tb/testbench.sv
